// ----- rtl/core/pidc_pkg.sv -----
// Shared types and constants for the PID controller step core.
`timescale 1ns / 1ps
`default_nettype none

package pidc_pkg;

  localparam int unsigned ERR_W   = 17;
  localparam int unsigned ISUM_W  = 31;
  localparam int unsigned SUM_W   = 48;
  localparam int unsigned DRIVE_W = 32;
  localparam int unsigned CIDX_W  = 3;
  localparam int unsigned CDAT_W  = 32;

  localparam logic [CIDX_W-1:0] REG_GAIN_P         = 3'd0;
  localparam logic [CIDX_W-1:0] REG_GAIN_I         = 3'd1;
  localparam logic [CIDX_W-1:0] REG_GAIN_D         = 3'd2;
  localparam logic [CIDX_W-1:0] REG_LOOP_MODE      = 3'd3;
  localparam logic [CIDX_W-1:0] REG_ERROR_LIMIT    = 3'd4;
  localparam logic [CIDX_W-1:0] REG_INTEGRAL_LIMIT = 3'd5;
  localparam logic [CIDX_W-1:0] REG_DRIVE_MAX      = 3'd6;
  localparam logic [CIDX_W-1:0] REG_DRIVE_MIN      = 3'd7;

  localparam logic [1:0] MODE_PI  = 2'd0;
  localparam logic [1:0] MODE_PD  = 2'd1;
  localparam logic [1:0] MODE_PID = 2'd2;

  localparam logic signed [SUM_W-1:0] SUM_INT32_MAX = 48'sh0000_7FFF_FFFF;
  localparam logic signed [SUM_W-1:0] SUM_INT32_MIN = -48'sh0000_8000_0000;

  typedef enum logic [1:0] {
    SAT_NONE,
    SAT_POS,
    SAT_NEG
  } sat_t;

  typedef struct packed {
    logic        [14:0] gain_p;
    logic        [14:0] gain_i;
    logic        [14:0] gain_d;
    logic        [1:0]  loop_mode;
    logic        [14:0] error_limit;
    logic        [29:0] integral_limit;
    logic signed [31:0] drive_max;
    logic signed [31:0] drive_min;
  } cfg_t;

  typedef struct packed {
    sat_t                     p_sat;
    logic signed [ERR_W-1:0]  err;
    sat_t                     i_sat;
    logic signed [ISUM_W-1:0] isum;
    logic signed [ERR_W-1:0]  ddiff;
    logic                     use_i;
    logic                     use_d;
  } err_stage_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic                    use_d;
  } sum_stage_t;

endpackage

`default_nettype wire

// ----- rtl/core/pid_controller_step_core.sv -----
// Top level of the fixed-point PID controller step core.
//
//  channel | signals                                   | role
//  --------+-------------------------------------------+-------------------------------
//  in      | in_valid, in_ready, setpoint, measured    | one sample per transaction
//  out     | out_valid, out_ready, drive               | one drive value per sample
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | register write, index 0..7
//
//  One sample per cycle sustained while out_ready is high; samples pass the s0,
//  es, pr, ss, q and drive registers. The accumulate-and-clamp loop feeds error_sum back directly.
//  Reset clears all valid flags, error_sum and last_measured, and loads the
//  register defaults. Each stage holds while its successor is full and stalled,
//  so in_ready drops only when the output register is held.
`timescale 1ns / 1ps
`default_nettype none

module pid_controller_step_core #(
  parameter int unsigned SCALE_SHIFT  = 7,
  parameter int unsigned P_TERM_LIMIT = 32767,
  parameter int unsigned I_TERM_LIMIT = 1073741823
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire  signed [15:0]           setpoint,
  input  wire  signed [15:0]           measured,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic signed [31:0]           drive,
  input  wire                          cfg_valid,
  output logic                         cfg_ready,
  input  wire  [pidc_pkg::CIDX_W-1:0]  cfg_index,
  input  wire  [pidc_pkg::CDAT_W-1:0]  cfg_data
);
  import pidc_pkg::*;

  cfg_t       cfg;
  logic       es_valid;
  logic       es_ready;
  err_stage_t es;
  logic       ss_valid;
  logic       ss_ready;
  sum_stage_t ss;

  pidc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pidc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .setpoint (setpoint),
    .measured (measured),
    .es_valid (es_valid),
    .es_ready (es_ready),
    .es       (es)
  );

  pidc_terms #(
    .P_TERM_LIMIT (P_TERM_LIMIT),
    .I_TERM_LIMIT (I_TERM_LIMIT)
  ) u_terms (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .es_valid (es_valid),
    .es_ready (es_ready),
    .es       (es),
    .ss_valid (ss_valid),
    .ss_ready (ss_ready),
    .ss       (ss)
  );

  pidc_out #(
    .SCALE_SHIFT (SCALE_SHIFT)
  ) u_out (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .ss_valid  (ss_valid),
    .ss_ready  (ss_ready),
    .ss        (ss),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .drive     (drive)
  );

  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled without a held result");

endmodule

`default_nettype wire

// ----- rtl/core/pidc_cfg.sv -----
// Configuration register file of the PID controller step core.
`timescale 1ns / 1ps
`default_nettype none

module pidc_cfg (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          cfg_valid,
  output logic                         cfg_ready,
  input  wire  [pidc_pkg::CIDX_W-1:0]  cfg_index,
  input  wire  [pidc_pkg::CDAT_W-1:0]  cfg_data,
  output pidc_pkg::cfg_t               cfg
);
  import pidc_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain_p         <= '0;
      cfg.gain_i         <= '0;
      cfg.gain_d         <= '0;
      cfg.loop_mode      <= MODE_PID;
      cfg.error_limit    <= 15'h7FFF;
      cfg.integral_limit <= 30'h3FFF_FFFF;
      cfg.drive_max      <= 32'sh7FFF_FFFF;
      cfg.drive_min      <= -32'sh8000_0000;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_GAIN_P:         cfg.gain_p         <= cfg_data[14:0];
        REG_GAIN_I:         cfg.gain_i         <= cfg_data[14:0];
        REG_GAIN_D:         cfg.gain_d         <= cfg_data[14:0];
        REG_LOOP_MODE:      cfg.loop_mode      <= cfg_data[1:0];
        REG_ERROR_LIMIT:    cfg.error_limit    <= cfg_data[14:0];
        REG_INTEGRAL_LIMIT: cfg.integral_limit <= cfg_data[29:0];
        REG_DRIVE_MAX:      cfg.drive_max      <= $signed(cfg_data);
        REG_DRIVE_MIN:      cfg.drive_min      <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/pidc_front.sv -----
// Input register, error, integral accumulator and derivative difference.
`timescale 1ns / 1ps
`default_nettype none

module pidc_front (
  input  wire                      clk,
  input  wire                      rst,
  input  pidc_pkg::cfg_t           cfg,
  input  wire                      in_valid,
  output logic                     in_ready,
  input  wire  signed [15:0]       setpoint,
  input  wire  signed [15:0]       measured,
  output logic                     es_valid,
  input  wire                      es_ready,
  output pidc_pkg::err_stage_t     es
);
  import pidc_pkg::*;

  logic                     s0_valid;
  logic signed [15:0]       s0_sp;
  logic signed [15:0]       s0_pv;
  logic                     s1_load;
  logic                     s0_fire;
  logic signed [ISUM_W-1:0] error_sum;
  logic signed [ISUM_W-1:0] error_sum_next;
  logic signed [15:0]       last_measured;
  logic signed [ERR_W-1:0]  err;
  logic signed [ERR_W-1:0]  lim;
  logic signed [31:0]       t;
  logic signed [31:0]       ilim;
  logic                     use_i;
  logic                     use_d;
  err_stage_t               es_next;

  assign s1_load  = !es_valid || es_ready;
  assign in_ready = !s0_valid || s1_load;
  assign s0_fire  = s0_valid && s1_load;

  assign use_i = (cfg.loop_mode != MODE_PD);
  assign use_d = (cfg.loop_mode != MODE_PI);

  always_comb begin
    err  = ERR_W'(s0_sp) - ERR_W'(s0_pv);
    lim  = $signed({2'b00, cfg.error_limit});
    t    = 32'(error_sum) + 32'(err);
    ilim = $signed({2'b00, cfg.integral_limit});

    es_next.err   = err;
    es_next.use_i = use_i;
    es_next.use_d = use_d;
    es_next.ddiff = ERR_W'(last_measured) - ERR_W'(s0_pv);

    if (err > lim) begin
      es_next.p_sat = SAT_POS;
    end else if (err < -lim) begin
      es_next.p_sat = SAT_NEG;
    end else begin
      es_next.p_sat = SAT_NONE;
    end

    if (t > ilim) begin
      es_next.i_sat  = SAT_POS;
      error_sum_next = ilim[ISUM_W-1:0];
    end else if (t < -ilim) begin
      es_next.i_sat  = SAT_NEG;
      error_sum_next = ISUM_W'(-ilim);
    end else begin
      es_next.i_sat  = SAT_NONE;
      error_sum_next = t[ISUM_W-1:0];
    end
    es_next.isum = error_sum_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid      <= 1'b0;
      es_valid      <= 1'b0;
      error_sum     <= '0;
      last_measured <= '0;
    end else begin
      if (in_ready) begin
        s0_valid <= in_valid;
      end
      if (s1_load) begin
        es_valid <= s0_valid;
      end
      if (s0_fire) begin
        last_measured <= s0_pv;
        if (use_i) begin
          error_sum <= error_sum_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      s0_sp <= setpoint;
      s0_pv <= measured;
    end
    if (s1_load) begin
      es <= es_next;
    end
  end

  a_sum_bounded: assert property (@(posedge clk) disable iff (rst)
    (s0_fire && use_i) |=>
      (32'(error_sum) <= $past(ilim) && 32'(error_sum) >= -$past(ilim)))
    else $error("error_sum left its clamp range");

  a_last_meas: assert property (@(posedge clk) disable iff (rst)
    s0_fire |=> (last_measured == $past(s0_pv)))
    else $error("last_measured not updated by a step");

endmodule

`default_nettype wire

// ----- rtl/core/pidc_terms.sv -----
// Proportional, integral and derivative products and their sum.
`timescale 1ns / 1ps
`default_nettype none

module pidc_terms #(
  parameter int unsigned P_TERM_LIMIT = 32767,
  parameter int unsigned I_TERM_LIMIT = 1073741823
) (
  input  wire                      clk,
  input  wire                      rst,
  input  pidc_pkg::cfg_t           cfg,
  input  wire                      es_valid,
  output logic                     es_ready,
  input  pidc_pkg::err_stage_t     es,
  output logic                     ss_valid,
  input  wire                      ss_ready,
  output pidc_pkg::sum_stage_t     ss
);
  import pidc_pkg::*;

  localparam logic signed [31:0]      P_LIM = 32'(P_TERM_LIMIT);
  localparam logic signed [SUM_W-1:0] I_LIM = SUM_W'(I_TERM_LIMIT);

  logic                    pr_valid;
  logic                    pr_load;
  logic                    ss_load;
  logic signed [32:0]      p_prod;
  logic signed [SUM_W-1:0] i_prod;
  logic signed [32:0]      d_prod;
  logic signed [31:0]      pterm_next;
  logic signed [SUM_W-1:0] iterm_next;
  logic signed [31:0]      dterm_next;
  logic signed [31:0]      pterm;
  logic signed [SUM_W-1:0] iterm;
  logic signed [31:0]      dterm;
  logic                    pr_use_d;

  assign ss_load  = !ss_valid || ss_ready;
  assign pr_load  = !pr_valid || ss_load;
  assign es_ready = pr_load;

  always_comb begin
    p_prod = $signed({1'b0, cfg.gain_p}) * es.err;
    i_prod = $signed({1'b0, cfg.gain_i}) * es.isum;
    d_prod = $signed({1'b0, cfg.gain_d}) * es.ddiff;

    case (es.p_sat)
      SAT_POS: pterm_next = P_LIM;
      SAT_NEG: pterm_next = -P_LIM;
      default: pterm_next = p_prod[31:0];
    endcase

    if (!es.use_i) begin
      iterm_next = '0;
    end else begin
      case (es.i_sat)
        SAT_POS: iterm_next = I_LIM;
        SAT_NEG: iterm_next = -I_LIM;
        default: iterm_next = i_prod;
      endcase
    end

    dterm_next = es.use_d ? d_prod[31:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pr_valid <= 1'b0;
      ss_valid <= 1'b0;
    end else begin
      if (pr_load) begin
        pr_valid <= es_valid;
      end
      if (ss_load) begin
        ss_valid <= pr_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pr_load) begin
      pterm    <= pterm_next;
      iterm    <= iterm_next;
      dterm    <= dterm_next;
      pr_use_d <= es.use_d;
    end
    if (ss_load) begin
      ss.sum   <= SUM_W'(pterm) + iterm + SUM_W'(dterm);
      ss.use_d <= pr_use_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/pidc_out.sv -----
// Scaling toward zero, output clamp and output register.
`timescale 1ns / 1ps
`default_nettype none

module pidc_out #(
  parameter int unsigned SCALE_SHIFT = 7
) (
  input  wire                      clk,
  input  wire                      rst,
  input  pidc_pkg::cfg_t           cfg,
  input  wire                      ss_valid,
  output logic                     ss_ready,
  input  pidc_pkg::sum_stage_t     ss,
  output logic                     out_valid,
  input  wire                      out_ready,
  output logic signed [31:0]       drive
);
  import pidc_pkg::*;

  localparam logic signed [SUM_W-1:0] BIAS = SUM_W'((64'd1 << SCALE_SHIFT) - 64'd1);

  logic                    q_valid;
  logic                    q_load;
  logic                    o_load;
  logic signed [SUM_W-1:0] q;
  logic signed [SUM_W-1:0] q_round;
  logic                    q_use_d;
  logic                    o_use_d;
  logic signed [SUM_W-1:0] dmax;
  logic signed [SUM_W-1:0] dmin;
  logic signed [31:0]      drive_next;

  assign o_load   = !out_valid || out_ready;
  assign q_load   = !q_valid || o_load;
  assign ss_ready = q_load;

  assign dmax = SUM_W'(cfg.drive_max);
  assign dmin = SUM_W'(cfg.drive_min);

  // negative sums are biased so the arithmetic shift truncates toward zero
  assign q_round = ss.sum[SUM_W-1] ? (ss.sum + BIAS) : ss.sum;

  always_comb begin
    if (q_use_d) begin
      if (q > dmax) begin
        drive_next = cfg.drive_max;
      end else if (q < dmin) begin
        drive_next = cfg.drive_min;
      end else begin
        drive_next = q[31:0];
      end
    end else begin
      if (q > SUM_INT32_MAX) begin
        drive_next = SUM_INT32_MAX[31:0];
      end else if (q < SUM_INT32_MIN) begin
        drive_next = SUM_INT32_MIN[31:0];
      end else begin
        drive_next = q[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (q_load) begin
        q_valid <= ss_valid;
      end
      if (o_load) begin
        out_valid <= q_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_load) begin
      q       <= q_round >>> SCALE_SHIFT;
      q_use_d <= ss.use_d;
    end
    if (o_load) begin
      drive   <= drive_next;
      o_use_d <= q_use_d;
    end
  end

  a_drive_clamped: assert property (@(posedge clk) disable iff (rst)
    (out_valid && o_use_d && cfg.drive_min <= cfg.drive_max) |->
      (drive <= cfg.drive_max && drive >= cfg.drive_min))
    else $error("PD/PID drive outside its limits");

endmodule

`default_nettype wire

// ----- verif/tb_pid_controller_step_core.sv -----
// Self-checking testbench for the PID controller step core: predicted drive vs. DUT drive.
`timescale 1ns / 1ps

module tb_pid_controller_step_core;
  import pidc_pkg::*;

  localparam int unsigned SCALE_SHIFT  = 7;
  localparam int unsigned P_TERM_LIMIT = 32767;
  localparam int unsigned I_TERM_LIMIT = 1073741823;
  localparam int DRIVE_TOP    = 32'sh7FFF_FFFF;
  localparam int DRIVE_BOTTOM = 32'sh8000_0000;
  localparam int unsigned LAT_GUARD   = 8;
  localparam int unsigned HOLD_CYCLES = 200;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned NUM_PHASES  = 12;

  class pid_drive_scoreboard;
    cfg_t               cfg;
    longint             error_sum;
    logic signed [15:0] last_measured;
    logic signed [31:0] expected_drive[$];
    int unsigned        fail_count;

    function new();
      cfg.gain_p         = '0;
      cfg.gain_i         = '0;
      cfg.gain_d         = '0;
      cfg.loop_mode      = MODE_PID;
      cfg.error_limit    = 15'h7FFF;
      cfg.integral_limit = 30'h3FFF_FFFF;
      cfg.drive_max      = DRIVE_TOP;
      cfg.drive_min      = DRIVE_BOTTOM;
      error_sum          = 0;
      last_measured      = '0;
      fail_count         = 0;
    endfunction

    function void write_reg(logic [CIDX_W-1:0] idx, logic [CDAT_W-1:0] data);
      case (idx)
        REG_GAIN_P:         cfg.gain_p = data[14:0];
        REG_GAIN_I:         cfg.gain_i = data[14:0];
        REG_GAIN_D:         cfg.gain_d = data[14:0];
        REG_LOOP_MODE:      cfg.loop_mode = data[1:0];
        REG_ERROR_LIMIT:    cfg.error_limit = data[14:0];
        REG_INTEGRAL_LIMIT: cfg.integral_limit = data[29:0];
        REG_DRIVE_MAX:      cfg.drive_max = data;
        REG_DRIVE_MIN:      cfg.drive_min = data;
        default: ;
      endcase
    endfunction

    function void note_sample(logic signed [15:0] sp, logic signed [15:0] mv);
      longint err, lim, ilim, acc, p_term, i_term, d_term, total, res;
      bit     use_i, use_d;
      err    = longint'(sp) - longint'(mv);
      lim    = longint'(cfg.error_limit);
      use_i  = (cfg.loop_mode != MODE_PD);
      use_d  = (cfg.loop_mode != MODE_PI);
      i_term = 0;
      d_term = 0;
      if (err > lim) begin
        p_term = longint'(P_TERM_LIMIT);
      end else if (err < -lim) begin
        p_term = -longint'(P_TERM_LIMIT);
      end else begin
        p_term = longint'(cfg.gain_p) * err;
      end
      if (use_i) begin
        ilim = longint'(cfg.integral_limit);
        acc  = error_sum + err;
        if (acc > ilim) begin
          error_sum = ilim;
          i_term    = longint'(I_TERM_LIMIT);
        end else if (acc < -ilim) begin
          error_sum = -ilim;
          i_term    = -longint'(I_TERM_LIMIT);
        end else begin
          error_sum = acc;
          i_term    = longint'(cfg.gain_i) * acc;
        end
      end
      if (use_d) d_term = longint'(cfg.gain_d) * (longint'(last_measured) - longint'(mv));
      last_measured = mv;
      total = p_term + i_term + d_term;
      res   = total / (longint'(1) << SCALE_SHIFT);
      if (use_d) begin
        if (res > longint'($signed(cfg.drive_max))) res = longint'($signed(cfg.drive_max));
        else if (res < longint'($signed(cfg.drive_min))) res = longint'($signed(cfg.drive_min));
      end else begin
        if (res > longint'(DRIVE_TOP)) res = longint'(DRIVE_TOP);
        else if (res < longint'(DRIVE_BOTTOM)) res = longint'(DRIVE_BOTTOM);
      end
      expected_drive.push_back(32'(res));
    endfunction

    function void check_drive(logic signed [31:0] actual);
      logic signed [31:0] exp_drive;
      if (expected_drive.size() == 0) begin
        $error("drive transaction with nothing expected, actual %0d", actual);
        fail_count++;
        return;
      end
      exp_drive = expected_drive.pop_front();
      if (actual !== exp_drive) begin
        $error("drive mismatch: expected %0d, actual %0d", exp_drive, actual);
        fail_count++;
      end
    endfunction

    function int unsigned pending();
      return expected_drive.size();
    endfunction
  endclass

  logic                     clk;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic signed [15:0]       setpoint = '0;
  logic signed [15:0]       measured = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [31:0]       drive;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CIDX_W-1:0]        cfg_index = '0;
  logic [CDAT_W-1:0]        cfg_data = '0;

  pid_drive_scoreboard sb;
  bit                  no_idle = 1'b0;
  bit                  hold_output = 1'b0;
  int unsigned         cycle_count = 0;

  pid_controller_step_core #(
    .SCALE_SHIFT (SCALE_SHIFT),
    .P_TERM_LIMIT(P_TERM_LIMIT),
    .I_TERM_LIMIT(I_TERM_LIMIT)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .setpoint (setpoint),
    .measured (measured),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .drive    (drive),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [31:0] with_junk(logic [31:0] v, int unsigned w);
    logic [31:0] mask;
    mask = (w >= 32) ? '1 : (32'h1 << w) - 32'h1;
    return ($urandom & ~mask) | (v & mask);
  endfunction

  function automatic logic [31:0] pick_unsigned(int unsigned w);
    logic [31:0] mask;
    mask = (w >= 32) ? '1 : (32'h1 << w) - 32'h1;
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return mask;
      2:       return $urandom_range(0, 255);
      3:       return $urandom_range(0, 32'h1 << (w / 2));
      default: return $urandom & mask;
    endcase
  endfunction

  function automatic logic signed [15:0] sat16(int v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return 16'(v);
  endfunction

  function automatic int extreme16();
    case ($urandom_range(0, 4))
      0:       return -32768;
      1:       return -1;
      2:       return 0;
      3:       return 1;
      default: return 32767;
    endcase
  endfunction

  function automatic cfg_t make_config(int gp, int gi, int gd, int mode, int elim, int ilim,
                                       int dmax, int dmin);
    cfg_t c;
    c.gain_p         = 15'(gp);
    c.gain_i         = 15'(gi);
    c.gain_d         = 15'(gd);
    c.loop_mode      = 2'(mode);
    c.error_limit    = 15'(elim);
    c.integral_limit = 30'(ilim);
    c.drive_max      = dmax;
    c.drive_min      = dmin;
    return c;
  endfunction

  function automatic cfg_t random_config();
    cfg_t c;
    int   span;
    c.gain_p         = 15'(pick_unsigned(15));
    c.gain_i         = 15'(pick_unsigned(15));
    c.gain_d         = 15'(pick_unsigned(15));
    c.loop_mode      = 2'($urandom_range(0, 3));
    c.error_limit    = 15'(pick_unsigned(15));
    c.integral_limit = 30'(pick_unsigned(30));
    span = 1 << 20;
    case ($urandom_range(0, 3))
      0: begin
        c.drive_max = DRIVE_TOP;
        c.drive_min = DRIVE_BOTTOM;
      end
      1: begin
        c.drive_max = int'($urandom_range(0, span));
        c.drive_min = -int'($urandom_range(0, span));
      end
      2: begin
        c.drive_max = -int'($urandom_range(1, span));
        c.drive_min = int'($urandom_range(1, span));
      end
      default: begin
        c.drive_max = $urandom;
        c.drive_min = $urandom;
      end
    endcase
    return c;
  endfunction

  task automatic cfg_write(input logic [CIDX_W-1:0] idx, input logic [CDAT_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
  endtask

  task automatic load_config(input cfg_t c);
    cfg_write(REG_GAIN_P, with_junk(32'(c.gain_p), 15));
    cfg_write(REG_GAIN_I, with_junk(32'(c.gain_i), 15));
    cfg_write(REG_GAIN_D, with_junk(32'(c.gain_d), 15));
    cfg_write(REG_LOOP_MODE, with_junk(32'(c.loop_mode), 2));
    cfg_write(REG_ERROR_LIMIT, with_junk(32'(c.error_limit), 15));
    cfg_write(REG_INTEGRAL_LIMIT, with_junk(32'(c.integral_limit), 30));
    cfg_write(REG_DRIVE_MAX, c.drive_max);
    cfg_write(REG_DRIVE_MIN, c.drive_min);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_sample(input logic signed [15:0] sp, input logic signed [15:0] mv);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    setpoint <= sp;
    measured <= mv;
    do @(posedge clk); while (!in_ready);
    sb.note_sample(sp, mv);
  endtask

  task automatic drain_pipeline();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (LAT_GUARD) @(posedge clk);
  endtask

  // output side: random stalls, one long hold on request
  initial begin
    int unsigned stall;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_output) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_output = 1'b0;
      end else begin
        stall = no_idle ? 0 : $urandom_range(0, 15);
        if (stall != 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      sb.check_drive(drive);
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    cfg_t        c;
    int unsigned p, n, items;
    int          windup, kind, e, sp_i, mv_i, track_mv, target;
    sb = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // PID: error limit edges and integral clamp both ways
    load_config(make_config(100, 3, 50, MODE_PID, 1000, 5000, DRIVE_TOP, DRIVE_BOTTOM));
    send_sample(16'sd0, 16'sd0);
    send_sample(16'sh7FFF, 16'sh8000);
    send_sample(16'sh8000, 16'sh7FFF);
    send_sample(16'sd1000, 16'sd0);
    send_sample(16'sd1001, 16'sd0);
    send_sample(16'sd0, 16'sd1000);
    send_sample(16'sd0, 16'sd1001);
    send_sample(-16'sd1, -16'sd1);
    drain_pipeline();

    // PD with crossed drive limits, error_sum must hold
    load_config(make_config(32767, 9, 32767, MODE_PD, 32767, 100, -100, 100));
    send_sample(16'sd0, 16'sh7FFF);
    send_sample(16'sd0, 16'sh8000);
    send_sample(16'sd5, 16'sd5);
    send_sample(16'sd0, 16'sd0);
    drain_pipeline();

    // undefined mode code runs as PID
    load_config(make_config(40, 2, 20, 3, 32767, 1 << 20, 1000, -1000));
    send_sample(16'sd500, 16'sd0);
    send_sample(-16'sd500, 16'sd200);
    send_sample(16'sd0, 16'sd0);
    drain_pipeline();

    // PI ignores drive limits
    load_config(make_config(32767, 32767, 32767, MODE_PI, 32767, 30'h3FFF_FFFF, 0, 0));
    send_sample(16'sh7FFF, 16'sh8000);
    send_sample(16'sh8000, 16'sh7FFF);
    send_sample(16'sd100, -16'sd100);
    drain_pipeline();

    track_mv = 0;
    target   = 0;
    for (p = 0; p < NUM_PHASES; p++) begin
      c      = random_config();
      windup = 0;
      case (p)
        0: begin
          c = make_config(32767, 32767, 32767, MODE_PID, 32767, 30'h3FFF_FFFF,
                          DRIVE_TOP, DRIVE_BOTTOM);
        end
        1: begin
          c.gain_p         = '0;
          c.gain_i         = '0;
          c.gain_d         = '0;
          c.error_limit    = '0;
          c.integral_limit = '0;
        end
        2, 6: begin
          // integrator winds up until the PI output saturates
          c.loop_mode      = MODE_PI;
          c.gain_i         = 15'h7FFF;
          c.integral_limit = 30'h3FFF_FFFF;
          windup           = (p == 2) ? 1 : -1;
        end
        4: c.loop_mode = 2'd3;
        default: ;
      endcase
      load_config(c);
      no_idle = (p % 4 == 3);
      items   = (windup != 0) ? 250 : 100;
      for (n = 0; n < items; n++) begin
        if (p == 7 && n == 30) hold_output = 1'b1;
        kind = $urandom_range(0, 9);
        if (windup != 0 && kind != 9) begin
          sp_i = windup * int'($urandom_range(16384, 32767));
          mv_i = -windup * int'($urandom_range(16384, 32767));
        end else if (kind < 6) begin
          track_mv = track_mv + int'($urandom_range(0, 200)) - 100;
          if ($urandom_range(0, 31) == 0) target = int'($urandom_range(0, 65535)) - 32768;
          sp_i = target;
          mv_i = track_mv;
        end else if (kind < 8) begin
          sp_i = int'($urandom_range(0, 65535)) - 32768;
          mv_i = int'($urandom_range(0, 65535)) - 32768;
        end else if (kind == 8) begin
          e = int'(sb.cfg.error_limit) + int'($urandom_range(0, 2)) - 1;
          if ($urandom_range(0, 1) == 1) e = -e;
          sp_i = int'($urandom_range(0, 65535)) - 32768;
          mv_i = sp_i - e;
        end else begin
          sp_i = extreme16();
          mv_i = extreme16();
        end
        track_mv = int'(sat16(mv_i));
        send_sample(sat16(sp_i), sat16(mv_i));
      end
      drain_pipeline();
    end

    if (sb.fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
